/* sv/ccam_pkg.sv */
// Package with the shared types and codes of the CAN command authority monitor.
package ccam_pkg;

  // Widths of the fields and registers.
  localparam int unsigned BusW     = 8;
  localparam int unsigned IdW      = 29;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned DataW    = 64;
  localparam int unsigned DlcW     = 4;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 3;

  // Bus number that marks an unusable profile.
  localparam logic [BusW-1:0] NoBus  = 8'hFF;
  // Largest data length code a profile may allow.
  localparam logic [DlcW-1:0] MaxDlc = 4'd8;
  // Bit of id_with_flags that marks an extended identifier.
  localparam int unsigned ExtFlagBit = 29;
  // Width of a standard identifier.
  localparam int unsigned StdIdW = 11;

  // Depth of the queue between front and back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  typedef enum logic [2:0] {
    OP_BEGIN   = 3'd0,
    OP_ARM     = 3'd1,
    OP_DISARM  = 3'd2,
    OP_FRAME   = 3'd3,
    OP_TICK    = 3'd4,
    OP_SERVICE = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    ST_UNKNOWN  = 3'd0,
    ST_ACTIVE   = 3'd1,
    ST_RECENT   = 3'd2,
    ST_INACTIVE = 3'd3,
    ST_FAULT    = 3'd4
  } auth_state_t;

  typedef enum logic [2:0] {
    DET_NONE     = 3'd0,
    DET_INVALID  = 3'd1,
    DET_MODE     = 3'd2,
    DET_ALIVE    = 3'd3,
    DET_REAPPEAR = 3'd4
  } detail_t;

  typedef enum logic [2:0] {
    CFG_MATCH_BUS      = 3'd0,
    CFG_MATCH_ID       = 3'd1,
    CFG_ID_MASK        = 3'd2,
    CFG_DLC_LIMITS     = 3'd3,
    CFG_MODE_CHECK     = 3'd4,
    CFG_ALIVE_CHECK    = 3'd5,
    CFG_ACTIVE_TIMEOUT = 3'd6,
    CFG_RELEASE_QUIET  = 3'd7
  } cfg_idx_t;

  // Outcome of matching one frame against the profile.
  typedef enum logic [1:0] {
    FC_NOMATCH     = 2'd0,
    FC_MATCH       = 2'd1,
    FC_FAULT_MODE  = 2'd2,
    FC_FAULT_ALIVE = 2'd3
  } frame_cls_t;

  // Configuration registers.
  typedef struct packed {
    logic [BusW-1:0]  match_bus;
    logic [IdW-1:0]   match_id;
    logic [IdW-1:0]   id_mask;
    logic [7:0]       dlc_limits;
    logic [11:0]      mode_check;
    logic [3:0]       alive_check;
    logic [TimeW-1:0] active_timeout;
    logic [TimeW-1:0] release_quiet;
  } ccam_cfg_t;

  // Classified item passed from front to back.
  typedef struct packed {
    logic [2:0]       op;
    logic [TimeW-1:0] now;
    frame_cls_t       cls;
    logic             prof_ok;
    logic             local_active;
  } ccam_item_t;

endpackage

/* sv/ccam_front.sv */
// Front end: decodes and classifies each accepted item against the profile.
module ccam_front (
  input  ccam_pkg::ccam_cfg_t      cfg,
  input  logic [2:0]               in_opcode,
  input  logic [31:0]              in_now_time,
  input  logic [7:0]               in_frame_bus,
  input  logic [31:0]              in_id_with_flags,
  input  logic [3:0]               in_frame_length,
  input  logic [63:0]              in_payload,
  input  logic                     in_local_active,
  output ccam_pkg::ccam_item_t     item
);
  import ccam_pkg::*;

  logic [DlcW-1:0] dlc_lo;
  logic [DlcW-1:0] dlc_hi;
  logic            mode_en;
  logic [2:0]      mode_off;
  logic [7:0]      mode_bits;
  logic            alive_en;
  logic [2:0]      alive_off;
  logic [IdW-1:0]  raw_id;
  logic [7:0]      mode_byte;
  logic            base_ok;
  logic            prof_ok;
  frame_cls_t      cls;

  assign dlc_lo    = cfg.dlc_limits[3:0];
  assign dlc_hi    = cfg.dlc_limits[7:4];
  assign mode_en   = cfg.mode_check[11];
  assign mode_off  = cfg.mode_check[10:8];
  assign mode_bits = cfg.mode_check[7:0];
  assign alive_en  = cfg.alive_check[3];
  assign alive_off = cfg.alive_check[2:0];

  // Extended frames keep all 29 identifier bits, standard frames the low 11.
  assign raw_id = in_id_with_flags[ExtFlagBit] ? in_id_with_flags[IdW-1:0]
                                               : {{(IdW-StdIdW){1'b0}},
                                                  in_id_with_flags[StdIdW-1:0]};

  assign mode_byte = in_payload[{mode_off, 3'b000} +: 8];

  // Bus, length window and masked identifier must all fit.
  assign base_ok = (in_frame_bus == cfg.match_bus) &&
                   (in_frame_length >= dlc_lo) && (in_frame_length <= dlc_hi) &&
                   ((raw_id & cfg.id_mask) == (cfg.match_id & cfg.id_mask));

  // Mode byte is checked before the alive byte; an offset at or past the DLC is a fault.
  always_comb begin
    cls = FC_MATCH;
    if (!base_ok) begin
      cls = FC_NOMATCH;
    end else if (mode_en && ({1'b0, mode_off} >= in_frame_length)) begin
      cls = FC_FAULT_MODE;
    end else if (mode_en && ((mode_byte & mode_bits) == 8'd0)) begin
      cls = FC_NOMATCH;
    end else if (alive_en && ({1'b0, alive_off} >= in_frame_length)) begin
      cls = FC_FAULT_ALIVE;
    end
  end

  // Profile validation for the arm command.
  always_comb begin
    prof_ok = 1'b1;
    if ((cfg.match_bus == NoBus) || (cfg.id_mask == '0) || (dlc_lo > dlc_hi) ||
        (dlc_hi > MaxDlc) || (cfg.active_timeout == '0) ||
        (cfg.release_quiet == '0)) begin
      prof_ok = 1'b0;
    end
    if (mode_en && ({1'b0, mode_off} >= dlc_lo)) begin
      prof_ok = 1'b0;
    end
    if (alive_en && ({1'b0, alive_off} >= dlc_lo)) begin
      prof_ok = 1'b0;
    end
  end

  assign item.op           = in_opcode;
  assign item.now          = in_now_time;
  assign item.cls          = cls;
  assign item.prof_ok      = prof_ok;
  assign item.local_active = in_local_active;

endmodule

/* sv/ccam_queue.sv */
// Short queue of classified items between the front and back ends.
module ccam_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ccam_pkg::ccam_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output ccam_pkg::ccam_item_t pop_item
);
  import ccam_pkg::*;

  ccam_item_t           mem_r [QDepth];
  logic [QPtrW-1:0]     wr_ptr_r;
  logic [QPtrW-1:0]     wr_ptr_nxt;
  logic [QPtrW-1:0]     rd_ptr_r;
  logic [QPtrW-1:0]     rd_ptr_nxt;
  logic [QCntW-1:0]     count_r;
  logic [QCntW-1:0]     count_nxt;

  assign full      = (count_r == QCntW'(QDepth));
  assign not_empty = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  // Pointer and fill count updates; push and pop may share a cycle.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* sv/ccam_back.sv */
// Back end: applies each item to the authority state and holds the result.
module ccam_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ccam_pkg::ccam_cfg_t  cfg,
  input  logic                 q_not_empty,
  input  ccam_pkg::ccam_item_t q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_authority_state,
  output logic                 out_quiet_satisfied,
  output logic                 out_tx_inhibit,
  output logic [2:0]           out_detail_code,
  output logic [31:0]          out_fault_total,
  output logic                 out_profile_armed,
  output logic                 out_frame_matched
);
  import ccam_pkg::*;

  auth_state_t      auth_r;
  auth_state_t      auth_nxt;
  logic [TimeW-1:0] last_cmd_r;
  logic [TimeW-1:0] last_cmd_nxt;
  logic             quiet_r;
  logic             quiet_nxt;
  logic             inhibit_r;
  logic             inhibit_nxt;
  detail_t          detail_r;
  detail_t          detail_nxt;
  logic [31:0]      fault_r;
  logic [31:0]      fault_nxt;
  logic             armed_r;
  logic             armed_nxt;
  logic             matched_r;
  logic             matched_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [TimeW-1:0] age;

  // Take the next item whenever the result slot is free or being taken.
  assign q_pop = q_not_empty && (!out_valid_r || out_ready);

  assign age = q_item.now - last_cmd_r;

  // Next state of the authority machine and its companion flags.
  always_comb begin
    auth_nxt     = auth_r;
    last_cmd_nxt = last_cmd_r;
    quiet_nxt    = quiet_r;
    inhibit_nxt  = inhibit_r;
    detail_nxt   = detail_r;
    fault_nxt    = fault_r;
    armed_nxt    = armed_r;
    matched_nxt  = 1'b0;
    case (q_item.op)
      OP_BEGIN: begin
        last_cmd_nxt = q_item.now;
        quiet_nxt    = 1'b0;
        inhibit_nxt  = 1'b0;
        detail_nxt   = DET_NONE;
        auth_nxt     = ST_UNKNOWN;
      end
      OP_ARM: begin
        if (!q_item.prof_ok) begin
          armed_nxt  = 1'b0;
          fault_nxt  = fault_r + 1'b1;
          detail_nxt = DET_INVALID;
          auth_nxt   = ST_FAULT;
        end else begin
          armed_nxt = 1'b1;
          quiet_nxt = 1'b0;
          auth_nxt  = ST_UNKNOWN;
        end
      end
      OP_DISARM: begin
        armed_nxt = 1'b0;
        quiet_nxt = 1'b0;
        auth_nxt  = ST_UNKNOWN;
      end
      OP_FRAME: begin
        if (!armed_r) begin
          auth_nxt = ST_UNKNOWN;
        end else begin
          case (q_item.cls)
            FC_MATCH: begin
              matched_nxt  = 1'b1;
              last_cmd_nxt = q_item.now;
              quiet_nxt    = 1'b0;
              auth_nxt     = ST_ACTIVE;
              if (q_item.local_active) begin
                inhibit_nxt = 1'b1;
                detail_nxt  = DET_REAPPEAR;
              end
            end
            FC_FAULT_MODE: begin
              fault_nxt  = fault_r + 1'b1;
              detail_nxt = DET_MODE;
              auth_nxt   = ST_FAULT;
            end
            FC_FAULT_ALIVE: begin
              fault_nxt  = fault_r + 1'b1;
              detail_nxt = DET_ALIVE;
              auth_nxt   = ST_FAULT;
            end
            default: begin
              auth_nxt = auth_r;
            end
          endcase
        end
      end
      OP_TICK: begin
        if (!armed_r) begin
          auth_nxt  = ST_UNKNOWN;
          quiet_nxt = 1'b0;
        end else begin
          // Active ages to recently active, which may settle to inactive at once.
          if ((auth_r == ST_ACTIVE) && (age > cfg.active_timeout)) begin
            auth_nxt = ST_RECENT;
          end
          if (((auth_r == ST_RECENT) ||
               ((auth_r == ST_ACTIVE) && (age > cfg.active_timeout))) &&
              (age >= cfg.release_quiet)) begin
            quiet_nxt = 1'b1;
            auth_nxt  = ST_INACTIVE;
          end
        end
      end
      OP_SERVICE: begin
        inhibit_nxt = 1'b0;
        detail_nxt  = DET_NONE;
        auth_nxt    = ST_UNKNOWN;
      end
      default: begin
        auth_nxt = auth_r;
      end
    endcase
  end

  // The result slot fills on a pop and empties when its transfer completes.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auth_r      <= ST_UNKNOWN;
      last_cmd_r  <= '0;
      quiet_r     <= 1'b0;
      inhibit_r   <= 1'b0;
      detail_r    <= DET_NONE;
      fault_r     <= '0;
      armed_r     <= 1'b0;
      matched_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        auth_r     <= auth_nxt;
        last_cmd_r <= last_cmd_nxt;
        quiet_r    <= quiet_nxt;
        inhibit_r  <= inhibit_nxt;
        detail_r   <= detail_nxt;
        fault_r    <= fault_nxt;
        armed_r    <= armed_nxt;
        matched_r  <= matched_nxt;
      end
    end
  end

  // The state registers change only with a pop, so they double as the result.
  always_comb begin
    out_valid           = out_valid_r;
    out_authority_state = auth_r;
    out_quiet_satisfied = quiet_r;
    out_tx_inhibit      = inhibit_r;
    out_detail_code     = detail_r;
    out_fault_total     = fault_r;
    out_profile_armed   = armed_r;
    out_frame_matched   = matched_r;
  end

  // The fault count moves only when an item is applied.
  a_fault_only_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !q_pop |=> $stable(fault_r))
    else $error("fault count changed without an applied item");

  // An armed matching frame always leaves the state active confirmed.
  a_match_goes_active: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (q_item.op == OP_FRAME) && (q_item.cls == FC_MATCH) && armed_r)
    |=> ((auth_r == ST_ACTIVE) && matched_r))
    else $error("matching frame did not confirm active authority");

  // A reported match comes with active state and an open quiet window.
  a_match_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    matched_r |-> ((auth_r == ST_ACTIVE) && !quiet_r))
    else $error("frame match reported with inconsistent state");

  // A result waiting untaken is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !q_pop)
    else $error("pending result overwritten");

endmodule

/* sv/can_command_authority_monitor.sv */
// Top level of the CAN command authority monitor: registers, front, queue, back.
//
//   Channel   Direction  Handshake             Payload
//   in_*      input      in_valid / in_ready   opcode, time, bus, id, DLC, data, local
//   out_*     output     out_valid / out_ready state, flags, detail, fault count, match
//   cfg_*     input      cfg_write_en          cfg_index, cfg_data (no read-back)
//
// One item per cycle is sustained while out_ready stays high; the back end's state update sets it.
// A result appears once its item is written to the queue and then applied by the state update.
// Reset is synchronous and clears state at once; no clearing pass is needed.
// The two-entry queue lets the front keep accepting while a result waits to be taken.
module can_command_authority_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [31:0] in_now_time,
  input  logic [7:0]  in_frame_bus,
  input  logic [31:0] in_id_with_flags,
  input  logic [3:0]  in_frame_length,
  input  logic [63:0] in_payload,
  input  logic        in_local_active,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_authority_state,
  output logic        out_quiet_satisfied,
  output logic        out_tx_inhibit,
  output logic [2:0]  out_detail_code,
  output logic [31:0] out_fault_total,
  output logic        out_profile_armed,
  output logic        out_frame_matched,
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ccam_pkg::*;

  ccam_cfg_t  cfg_r;
  ccam_item_t front_item;
  ccam_item_t q_item;
  logic       q_full;
  logic       q_not_empty;
  logic       q_pop;
  logic       push;

  // Configuration registers; each write keeps only the register's width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.match_bus      <= NoBus;
      cfg_r.match_id       <= '0;
      cfg_r.id_mask        <= '0;
      cfg_r.dlc_limits     <= '0;
      cfg_r.mode_check     <= '0;
      cfg_r.alive_check    <= '0;
      cfg_r.active_timeout <= '0;
      cfg_r.release_quiet  <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_MATCH_BUS:      cfg_r.match_bus      <= cfg_data[BusW-1:0];
        CFG_MATCH_ID:       cfg_r.match_id       <= cfg_data[IdW-1:0];
        CFG_ID_MASK:        cfg_r.id_mask        <= cfg_data[IdW-1:0];
        CFG_DLC_LIMITS:     cfg_r.dlc_limits     <= cfg_data[7:0];
        CFG_MODE_CHECK:     cfg_r.mode_check     <= cfg_data[11:0];
        CFG_ALIVE_CHECK:    cfg_r.alive_check    <= cfg_data[3:0];
        CFG_ACTIVE_TIMEOUT: cfg_r.active_timeout <= cfg_data[TimeW-1:0];
        CFG_RELEASE_QUIET:  cfg_r.release_quiet  <= cfg_data[TimeW-1:0];
        default:            cfg_r.release_quiet  <= cfg_r.release_quiet;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  ccam_front u_front (
    .cfg              (cfg_r),
    .in_opcode        (in_opcode),
    .in_now_time      (in_now_time),
    .in_frame_bus     (in_frame_bus),
    .in_id_with_flags (in_id_with_flags),
    .in_frame_length  (in_frame_length),
    .in_payload       (in_payload),
    .in_local_active  (in_local_active),
    .item             (front_item)
  );

  ccam_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_item)
  );

  ccam_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .q_not_empty         (q_not_empty),
    .q_item              (q_item),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_authority_state (out_authority_state),
    .out_quiet_satisfied (out_quiet_satisfied),
    .out_tx_inhibit      (out_tx_inhibit),
    .out_detail_code     (out_detail_code),
    .out_fault_total     (out_fault_total),
    .out_profile_armed   (out_profile_armed),
    .out_frame_matched   (out_frame_matched)
  );

endmodule

/* bench/can_command_authority_monitor_tb.sv */
// Self-checking testbench for the CAN command authority monitor.
`timescale 1ns / 100ps

module can_command_authority_monitor_tb;
  import ccam_pkg::*;

  // Opcodes the block leaves unused; they only report the state.
  localparam logic [2:0] SpareOp6 = 3'd6;
  localparam logic [2:0] SpareOp7 = 3'd7;

  // One command as it travels on the input channel.
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] stamp;
    logic [7:0]  bus;
    logic [31:0] idf;
    logic [3:0]  dlc;
    logic [63:0] data;
    logic        local_act;
  } can_cmd_t;

  // One authority report as it leaves on the result channel.
  typedef struct packed {
    auth_state_t state;
    logic        quiet;
    logic        inhibit;
    detail_t     detail;
    logic [31:0] faults;
    logic        armed;
    logic        matched;
  } authority_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_opcode = '0;
  logic [31:0] in_now_time = '0;
  logic [7:0]  in_frame_bus = '0;
  logic [31:0] in_id_with_flags = '0;
  logic [3:0]  in_frame_length = '0;
  logic [63:0] in_payload = '0;
  logic        in_local_active = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_authority_state;
  logic        out_quiet_satisfied;
  logic        out_tx_inhibit;
  logic [2:0]  out_detail_code;
  logic [31:0] out_fault_total;
  logic        out_profile_armed;
  logic        out_frame_matched;
  logic        cfg_write_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  can_command_authority_monitor dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_now_time         (in_now_time),
    .in_frame_bus        (in_frame_bus),
    .in_id_with_flags    (in_id_with_flags),
    .in_frame_length     (in_frame_length),
    .in_payload          (in_payload),
    .in_local_active     (in_local_active),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_authority_state (out_authority_state),
    .out_quiet_satisfied (out_quiet_satisfied),
    .out_tx_inhibit      (out_tx_inhibit),
    .out_detail_code     (out_detail_code),
    .out_fault_total     (out_fault_total),
    .out_profile_armed   (out_profile_armed),
    .out_frame_matched   (out_frame_matched),
    .cfg_write_en        (cfg_write_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // Free-running clock, 4 ns period.
  initial forever #2 clk = ~clk;

  // Shadow of the profile registers and of the authority state.
  ccam_cfg_t   prof;
  auth_state_t auth_now;
  logic [31:0] last_cmd_ms;
  logic        quiet_now;
  logic        inhibit_now;
  detail_t     detail_now;
  logic [31:0] fault_count;
  logic        armed_now;

  authority_report_t expected_reports[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned regs_written = 0;
  int unsigned predicted_matches = 0;
  logic [31:0] clock_ms = '0;

  task automatic reset_model();
    prof = '0;
    prof.match_bus = NoBus;
    auth_now = ST_UNKNOWN;
    last_cmd_ms = '0;
    quiet_now = 1'b0;
    inhibit_now = 1'b0;
    detail_now = DET_NONE;
    fault_count = '0;
    armed_now = 1'b0;
  endtask

  // Register writes land in the shadow masked to each register's width.
  task automatic store_reg(cfg_idx_t idx, logic [31:0] value);
    case (idx)
      CFG_MATCH_BUS:      prof.match_bus = value[BusW-1:0];
      CFG_MATCH_ID:       prof.match_id = value[IdW-1:0];
      CFG_ID_MASK:        prof.id_mask = value[IdW-1:0];
      CFG_DLC_LIMITS:     prof.dlc_limits = value[7:0];
      CFG_MODE_CHECK:     prof.mode_check = value[11:0];
      CFG_ALIVE_CHECK:    prof.alive_check = value[3:0];
      CFG_ACTIVE_TIMEOUT: prof.active_timeout = value;
      default:            prof.release_quiet = value;
    endcase
  endtask

  function automatic void note_fault(detail_t code);
    fault_count = fault_count + 32'd1;
    detail_now = code;
    auth_now = ST_FAULT;
  endfunction

  // Arm only accepts a profile that can ever match and ever time out.
  function automatic logic profile_usable();
    logic [3:0] lo;
    logic [3:0] hi;
    lo = prof.dlc_limits[3:0];
    hi = prof.dlc_limits[7:4];
    if (prof.match_bus == NoBus || prof.id_mask == '0 || lo > hi || hi > MaxDlc ||
        prof.active_timeout == '0 || prof.release_quiet == '0)
      return 1'b0;
    if (prof.mode_check[11] && {1'b0, prof.mode_check[10:8]} >= lo) return 1'b0;
    if (prof.alive_check[3] && {1'b0, prof.alive_check[2:0]} >= lo) return 1'b0;
    return 1'b1;
  endfunction

  // Match a frame against the live profile; the mode byte is checked before the alive byte.
  function automatic frame_cls_t classify_frame(can_cmd_t c);
    logic [3:0]  lo;
    logic [3:0]  hi;
    logic [28:0] raw;
    logic [2:0]  off;
    lo = prof.dlc_limits[3:0];
    hi = prof.dlc_limits[7:4];
    if (c.bus != prof.match_bus || c.dlc < lo || c.dlc > hi) return FC_NOMATCH;
    raw = c.idf[ExtFlagBit] ? c.idf[28:0] : {18'd0, c.idf[10:0]};
    if ((raw & prof.id_mask) != (prof.match_id & prof.id_mask)) return FC_NOMATCH;
    if (prof.mode_check[11]) begin
      off = prof.mode_check[10:8];
      if ({1'b0, off} >= c.dlc) return FC_FAULT_MODE;
      if ((c.data[8*off +: 8] & prof.mode_check[7:0]) == 8'd0) return FC_NOMATCH;
    end
    if (prof.alive_check[3] && {1'b0, prof.alive_check[2:0]} >= c.dlc) return FC_FAULT_ALIVE;
    return FC_MATCH;
  endfunction

  // Advance the shadow state by one command and return the report it should produce.
  function automatic authority_report_t apply_command(can_cmd_t c);
    authority_report_t r;
    frame_cls_t        cls;
    logic [31:0]       age;
    logic              hit;
    hit = 1'b0;
    case (c.op)
      OP_BEGIN: begin
        last_cmd_ms = c.stamp;
        quiet_now = 1'b0;
        inhibit_now = 1'b0;
        detail_now = DET_NONE;
        auth_now = ST_UNKNOWN;
      end
      OP_ARM: begin
        if (!profile_usable()) begin
          armed_now = 1'b0;
          note_fault(DET_INVALID);
        end else begin
          armed_now = 1'b1;
          quiet_now = 1'b0;
          auth_now = ST_UNKNOWN;
        end
      end
      OP_DISARM: begin
        armed_now = 1'b0;
        quiet_now = 1'b0;
        auth_now = ST_UNKNOWN;
      end
      OP_FRAME: begin
        if (!armed_now) begin
          auth_now = ST_UNKNOWN;
        end else begin
          cls = classify_frame(c);
          case (cls)
            FC_MATCH: begin
              hit = 1'b1;
              last_cmd_ms = c.stamp;
              quiet_now = 1'b0;
              auth_now = ST_ACTIVE;
              if (c.local_act) begin
                inhibit_now = 1'b1;
                detail_now = DET_REAPPEAR;
              end
            end
            FC_FAULT_MODE:  note_fault(DET_MODE);
            FC_FAULT_ALIVE: note_fault(DET_ALIVE);
            default: ;
          endcase
        end
      end
      OP_TICK: begin
        if (!armed_now) begin
          auth_now = ST_UNKNOWN;
          quiet_now = 1'b0;
        end else begin
          age = c.stamp - last_cmd_ms;
          if (auth_now == ST_ACTIVE && age > prof.active_timeout) auth_now = ST_RECENT;
          if (auth_now == ST_RECENT && age >= prof.release_quiet) begin
            quiet_now = 1'b1;
            auth_now = ST_INACTIVE;
          end
        end
      end
      OP_SERVICE: begin
        inhibit_now = 1'b0;
        detail_now = DET_NONE;
        auth_now = ST_UNKNOWN;
      end
      default: ;
    endcase
    r.state = auth_now;
    r.quiet = quiet_now;
    r.inhibit = inhibit_now;
    r.detail = detail_now;
    r.faults = fault_count;
    r.armed = armed_now;
    r.matched = hit;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("MISMATCH at report %0d, %s: got 0x%0h, expected 0x%0h",
               results_seen, what, got, want);
  endtask

  // Offer one command, idling first at random, and record its expected report on transfer.
  task automatic send_item(can_cmd_t c);
    authority_report_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= c.op;
    in_now_time <= c.stamp;
    in_frame_bus <= c.bus;
    in_id_with_flags <= c.idf;
    in_frame_length <= c.dlc;
    in_payload <= c.data;
    in_local_active <= c.local_act;
    do @(posedge clk); while (!in_ready);
    want = apply_command(c);
    expected_reports.push_back(want);
    items_sent++;
    if (want.matched) predicted_matches++;
  endtask

  // Stop offering and wait until every expected report has come back.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    store_reg(idx, value);
    regs_written++;
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic can_cmd_t random_cmd(logic [2:0] op, logic [31:0] stamp);
    can_cmd_t c;
    c.op = op;
    c.stamp = stamp;
    c.bus = 8'($urandom);
    c.idf = $urandom;
    c.dlc = 4'($urandom);
    c.data = {$urandom, $urandom};
    c.local_act = 1'($urandom);
    return c;
  endfunction

  function automatic can_cmd_t frame_cmd(logic [7:0] bus, logic [31:0] idf, logic [3:0] dlc,
                                         logic [63:0] data, logic local_act,
                                         logic [31:0] stamp);
    can_cmd_t c;
    c.op = OP_FRAME;
    c.stamp = stamp;
    c.bus = bus;
    c.idf = idf;
    c.dlc = dlc;
    c.data = data;
    c.local_act = local_act;
    return c;
  endfunction

  // Build a frame that mostly fits the live profile; a spoiled one has one field disturbed.
  function automatic can_cmd_t command_frame(logic good);
    can_cmd_t    c;
    logic [28:0] raw;
    logic [3:0]  lo;
    logic [3:0]  hi;
    logic [2:0]  off;
    lo = prof.dlc_limits[3:0];
    hi = prof.dlc_limits[7:4];
    c = random_cmd(OP_FRAME, clock_ms);
    c.bus = prof.match_bus;
    if (lo <= hi) c.dlc = 4'($urandom_range(lo, hi));
    raw = (prof.match_id & prof.id_mask) | (29'($urandom) & ~prof.id_mask);
    if (((prof.match_id & prof.id_mask) >> StdIdW) == '0 && $urandom_range(0, 1) == 1)
      c.idf = {2'($urandom), 1'b0, 18'($urandom), raw[10:0]};
    else
      c.idf = {2'($urandom), 1'b1, raw};
    if (prof.mode_check[11] && $urandom_range(0, 4) != 0) begin
      off = prof.mode_check[10:8];
      c.data[8*off +: 8] = 8'($urandom) |
                           (prof.mode_check[7:0] & (~prof.mode_check[7:0] + 8'd1));
    end
    if (!good) begin
      case ($urandom_range(0, 3))
        0:       c.bus = c.bus ^ (8'd1 << $urandom_range(0, 7));
        1:       c.idf = c.idf ^ (32'd1 << $urandom_range(0, 31));
        2:       c.dlc = 4'($urandom);
        default: c.data = {$urandom, $urandom};
      endcase
    end
    return c;
  endfunction

  // Narrow registers sometimes get junk above their width, which must be dropped.
  function automatic logic [31:0] with_junk(logic [31:0] value, int unsigned w);
    if (w < 32 && $urandom_range(0, 5) == 0) return value | ($urandom << w);
    return value;
  endfunction

  // Write a fresh profile: mostly usable, sometimes broken by one chosen disturbance.
  task automatic program_random_profile();
    logic [7:0]  bus;
    logic [28:0] id;
    logic [28:0] mask;
    int unsigned lo;
    int unsigned hi;
    logic [11:0] mode;
    logic [3:0]  alive;
    logic [31:0] t_act;
    logic [31:0] t_quiet;
    bus = 8'($urandom_range(0, 254));
    if ($urandom_range(0, 9) == 0) bus = ($urandom_range(0, 1) == 1) ? 8'd0 : 8'd254;
    id = 29'($urandom);
    case ($urandom_range(0, 3))
      0:       mask = '1;
      1:       mask = 29'h7FF;
      2:       mask = 29'h1;
      default: mask = 29'($urandom);
    endcase
    if (mask == '0) mask = 29'h400;
    lo = $urandom_range(0, 8);
    hi = $urandom_range(lo, 8);
    mode = '0;
    alive = '0;
    if (lo != 0 && $urandom_range(0, 1) == 1)
      mode = {1'b1, 3'($urandom_range(0, lo - 1)), 8'($urandom)};
    if (lo != 0 && $urandom_range(0, 1) == 1)
      alive = {1'b1, 3'($urandom_range(0, lo - 1))};
    t_act = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : 32'($urandom_range(1, 30));
    t_quiet = ($urandom_range(0, 9) == 0) ? 32'd1 : 32'($urandom_range(1, 40));
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 7))
        0: bus = NoBus;
        1: mask = '0;
        2: begin
          lo = $urandom_range(1, 8);
          hi = $urandom_range(0, lo - 1);
        end
        3: hi = $urandom_range(9, 15);
        4: t_act = '0;
        5: t_quiet = '0;
        6: if (lo <= 7) mode = {1'b1, 3'($urandom_range(lo, 7)), 8'($urandom)};
        default: if (lo <= 7) alive = {1'b1, 3'($urandom_range(lo, 7))};
      endcase
    end
    write_reg(CFG_MATCH_BUS, with_junk({24'd0, bus}, BusW));
    write_reg(CFG_MATCH_ID, with_junk({3'd0, id}, IdW));
    write_reg(CFG_ID_MASK, with_junk({3'd0, mask}, IdW));
    write_reg(CFG_DLC_LIMITS, with_junk({24'd0, 4'(hi), 4'(lo)}, 8));
    write_reg(CFG_MODE_CHECK, with_junk({20'd0, mode}, 12));
    write_reg(CFG_ALIVE_CHECK, with_junk({28'd0, alive}, 4));
    write_reg(CFG_ACTIVE_TIMEOUT, t_act);
    write_reg(CFG_RELEASE_QUIET, t_quiet);
  endtask

  // Out of reset nothing is armed, and the default profile is rejected, lacking a bus, a mask and timeouts.
  task automatic test_unarmed_defaults();
    send_item(random_cmd(OP_FRAME, clock_ms));
    send_item(random_cmd(OP_TICK, clock_ms));
    send_item(random_cmd(OP_ARM, clock_ms));
    send_item(random_cmd(SpareOp6, clock_ms));
    send_item(random_cmd(SpareOp7, clock_ms));
    send_item(random_cmd(OP_SERVICE, clock_ms));
    send_item(random_cmd(OP_BEGIN, 32'hFFFF_FFFF));
  endtask

  // A command frame, DLC and mode misses, then aging through both windows across the wrap.
  task automatic test_command_tracking();
    settle();
    write_reg(CFG_MATCH_BUS, 32'hABCD_EF00);
    write_reg(CFG_MATCH_ID, 32'hFFFF_FFFF);
    write_reg(CFG_ID_MASK, 32'hFFFF_FFFF);
    write_reg(CFG_DLC_LIMITS, 32'h0000_0081);
    write_reg(CFG_MODE_CHECK, 32'hFFFF_F880);
    write_reg(CFG_ALIVE_CHECK, 32'h0000_0008);
    write_reg(CFG_ACTIVE_TIMEOUT, 32'd1);
    write_reg(CFG_RELEASE_QUIET, 32'd3);
    send_item(random_cmd(OP_ARM, 32'hFFFF_FFFE));
    send_item(random_cmd(OP_BEGIN, 32'hFFFF_FFFE));
    send_item(frame_cmd(8'd0, 32'hFFFF_FFFF, 4'd8, '1, 1'b1, 32'hFFFF_FFFF));
    send_item(frame_cmd(8'd0, 32'hFFFF_FFFF, 4'd0, '0, 1'b0, 32'hFFFF_FFFF));
    send_item(frame_cmd(8'd0, 32'hFFFF_FFFF, 4'd15, '1, 1'b1, 32'hFFFF_FFFF));
    send_item(frame_cmd(8'd0, 32'hFFFF_FFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FF7F, 1'b1,
                        32'hFFFF_FFFF));
    send_item(random_cmd(OP_TICK, 32'd0));
    send_item(random_cmd(OP_TICK, 32'd1));
    send_item(random_cmd(OP_TICK, 32'd2));
    send_item(random_cmd(OP_SERVICE, 32'd2));
  endtask

  // Profile edits after arming act at once: offset faults, standard identifiers, disarm.
  task automatic test_live_profile();
    settle();
    write_reg(CFG_MODE_CHECK, 32'h0000_0F01);
    send_item(frame_cmd(8'd0, 32'hFFFF_FFFF, 4'd1, '1, 1'b1, 32'd3));
    settle();
    write_reg(CFG_MODE_CHECK, 32'd0);
    write_reg(CFG_ALIVE_CHECK, 32'h0000_000F);
    send_item(frame_cmd(8'd0, 32'hFFFF_FFFF, 4'd1, '1, 1'b1, 32'd4));
    settle();
    write_reg(CFG_ALIVE_CHECK, 32'd0);
    write_reg(CFG_MATCH_ID, 32'h0000_07FF);
    send_item(frame_cmd(8'd0, 32'h0000_07FF, 4'd1, 64'h80, 1'b0, 32'd5));
    send_item(frame_cmd(8'd0, 32'hDFFF_FFFF, 4'd2, 64'h8080, 1'b1, 32'd6));
    send_item(frame_cmd(8'd0, 32'h2000_07FF, 4'd1, 64'hFF, 1'b0, 32'd7));
    send_item(random_cmd(OP_DISARM, 32'd8));
    send_item(frame_cmd(8'd0, 32'h0000_07FF, 4'd1, 64'h80, 1'b1, 32'd9));
    send_item(random_cmd(OP_TICK, 32'd10));
  endtask

  // Random profiles, each followed by a burst of mostly well-formed command traffic.
  task automatic run_traffic_stage(int unsigned send_pct, int unsigned recv_pct,
                                   int unsigned budget);
    int unsigned done;
    int unsigned span;
    int unsigned pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    done = 0;
    while (done < budget) begin
      settle();
      program_random_profile();
      if ($urandom_range(0, 9) == 0) clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
      if ($urandom_range(0, 3) != 0) send_item(random_cmd(OP_ARM, clock_ms));
      if ($urandom_range(0, 1) == 1) send_item(random_cmd(OP_BEGIN, clock_ms));
      span = $urandom_range(20, 70);
      repeat (span) begin
        // Now and then hold off until the block has answered everything.
        if ($urandom_range(0, 59) == 0) settle();
        if ($urandom_range(0, 29) == 0) clock_ms = clock_ms + 32'($urandom_range(0, 400));
        else clock_ms = clock_ms + 32'($urandom_range(0, 5));
        pick = $urandom_range(0, 99);
        if (pick < 45)      send_item(command_frame(1'b1));
        else if (pick < 65) send_item(random_cmd(OP_TICK, clock_ms));
        else if (pick < 73) send_item(command_frame(1'b0));
        else if (pick < 77) send_item(random_cmd(OP_SERVICE, clock_ms));
        else if (pick < 80) send_item(random_cmd(OP_BEGIN, clock_ms));
        else if (pick < 82) send_item(random_cmd(OP_DISARM, clock_ms));
        else if (pick < 85) send_item(random_cmd(OP_ARM, clock_ms));
        else send_item(random_cmd(3'($urandom_range(0, 7)), $urandom));
      end
      done += span;
    end
  endtask

  // Compare every report transfer with the oldest expectation; stall the receiver at random.
  always @(posedge clk) begin : check_reports
    authority_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("report with nothing expected", {29'd0, out_authority_state}, '0);
      end else begin
        want = expected_reports.pop_front();
        if (out_authority_state !== want.state)
          report_mismatch("authority_state", {29'd0, out_authority_state}, {29'd0, want.state});
        if (out_quiet_satisfied !== want.quiet)
          report_mismatch("quiet_satisfied", {31'd0, out_quiet_satisfied}, {31'd0, want.quiet});
        if (out_tx_inhibit !== want.inhibit)
          report_mismatch("tx_inhibit", {31'd0, out_tx_inhibit}, {31'd0, want.inhibit});
        if (out_detail_code !== want.detail)
          report_mismatch("detail_code", {29'd0, out_detail_code}, {29'd0, want.detail});
        if (out_fault_total !== want.faults)
          report_mismatch("fault_total", out_fault_total, want.faults);
        if (out_profile_armed !== want.armed)
          report_mismatch("profile_armed", {31'd0, out_profile_armed}, {31'd0, want.armed});
        if (out_frame_matched !== want.matched)
          report_mismatch("frame_matched", {31'd0, out_frame_matched}, {31'd0, want.matched});
      end
      results_seen++;
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Watchdog expired with %0d reports outstanding", expected_reports.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    reset_model();
    send_idle_pct = 28;
    recv_idle_pct = 78;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unarmed_defaults();
    test_command_tracking();
    test_live_profile();
    run_traffic_stage(28, 78, 600);
    run_traffic_stage(78, 28, 600);
    run_traffic_stage(0, 0, 600);

    settle();
    repeat (8) @(posedge clk);

    $display("Sent %0d commands, checked %0d reports, made %0d register writes.",
             items_sent, results_seen, regs_written);
    $display("Predicted %0d profile matches and %0d protocol faults under three idle mixes.",
             predicted_matches, fault_count);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/ccam_pkg.sv
sv/ccam_front.sv
sv/ccam_queue.sv
sv/ccam_back.sv
sv/can_command_authority_monitor.sv
bench/can_command_authority_monitor_tb.sv
